// ===== rtl/ura_pkg.sv =====
// ura_pkg: shared widths, register indexes, reset values and scaling constants
// for the ultrasonic range averager. No dependencies; used by ura_out_if and the
// top level.
package ura_pkg;

    // number of readings averaged per result (default of the top-level parameter)
    localparam int SAMPLES_DEF = 3;

    // field and register widths
    localparam int DIST_W      = 10;
    localparam int TICK_W      = 20;
    localparam int PRESC_W     = 16;
    localparam int UNITS_W     = 16;
    localparam int SUM_W       = 13;
    localparam int LEN_W       = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIGGER_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_PRESCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_TOP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS       = 3'd5;

    // register values after reset
    localparam logic [9:0]  RST_TRIGGER_TICKS   = 10'd20;
    localparam logic [19:0] RST_RETRIGGER_TICKS = 20'd40020;
    localparam logic [15:0] RST_UNIT_PRESCALE   = 16'd100;
    localparam logic [15:0] RST_COUNT_TOP       = 16'd999;
    localparam logic [9:0]  RST_MAX_DISTANCE    = 10'd300;
    localparam logic [19:0] RST_GAP_TICKS       = 20'd100000;

    // floor(units * 100 / 58) == (units * DIST_MUL) >> DIST_SHIFT for any 16-bit units
    localparam int               DIST_SHIFT = 21;
    localparam logic [21:0]      DIST_MUL   = 22'd3615780;
    localparam int               DIST_PROD_W = UNITS_W + 22;

    // shift used for the mean's reciprocal multiply
    localparam int MEAN_SHIFT = 16;

endpackage

// ===== rtl/ura_in_if.sv =====
// ura_in_if: input channel of the range averager, one beat per timebase tick.
// Takes nothing from ura_pkg; it carries only the handshake and the echo level.
interface ura_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

// ===== rtl/ura_out_if.sv =====
// ura_out_if: result channel of the range averager, one beat per tick taken.
// Depends on ura_pkg for the distance width.
interface ura_out_if;
    logic                       valid;
    logic                       ready;
    logic                       trigger_level;
    logic                       distance_valid;
    logic [ura_pkg::DIST_W-1:0] distance;

    modport source (output valid, output trigger_level, output distance_valid,
                    output distance, input ready);
    modport sink   (input valid, input trigger_level, input distance_valid,
                    input distance, output ready);
endinterface

// ===== rtl/ultrasonic_range_averager.sv =====
// Ultrasonic range averager: one beat in per timebase tick carrying the sampled
// echo level, one beat out per tick with the trigger drive, and every SAMPLES
// readings the truncated mean distance in centimetres. The block takes a tick in
// every clock cycle while the result side keeps up. The path runs through five
// registers: the input register, the ranging control step (phase, tick,
// prescale and unit counters), the centimetre scaling multiply, the saturate
// and accumulate step, and the mean multiply into the output register. Each
// stage holds its beat while the stage after it is full, so a stall on the
// result side fills the pipe before the input stops taking ticks. Configuration
// is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must do so only
// while no tick is in flight, as the block itself does not enforce this.
// Depends on ura_pkg, ura_in_if and ura_out_if.
module ultrasonic_range_averager #(
    parameter int SAMPLES = ura_pkg::SAMPLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ura_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ura_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ura_in_if.sink                         i_tick,
    ura_out_if.source                      o_res
);

    localparam int IDX_W = $clog2(SAMPLES + 1);
    // ceil(2^MEAN_SHIFT / SAMPLES) gives an exact floor for every 13-bit sum
    localparam logic [ura_pkg::MEAN_SHIFT:0] MEAN_MUL =
        (ura_pkg::MEAN_SHIFT + 1)'(((1 << ura_pkg::MEAN_SHIFT) + SAMPLES - 1) / SAMPLES);
    localparam int MEAN_PROD_W = ura_pkg::SUM_W + ura_pkg::MEAN_SHIFT + 1;

    typedef enum logic [1:0] {
        PH_TRIGGER,
        PH_WAIT,
        PH_MEASURE,
        PH_GAP
    } t_phase;

    // configuration registers
    logic [9:0]                      r_trigger_ticks;
    logic [ura_pkg::TICK_W-1:0]      r_retrigger_ticks;
    logic [ura_pkg::PRESC_W-1:0]     r_unit_prescale;
    logic [ura_pkg::UNITS_W-1:0]     r_count_top;
    logic [ura_pkg::DIST_W-1:0]      r_max_distance;
    logic [ura_pkg::TICK_W-1:0]      r_gap_ticks;

    // ranging control state
    t_phase                          r_phase, n_phase;
    logic [ura_pkg::TICK_W-1:0]      r_tick, n_tick;
    logic [ura_pkg::PRESC_W-1:0]     r_presc, n_presc;
    logic [ura_pkg::UNITS_W-1:0]     r_units, n_units;

    // averaging state
    logic [IDX_W-1:0]                r_idx;
    logic [ura_pkg::SUM_W-1:0]       r_sum;

    // pipeline registers
    logic                            r_v0, r_v1, r_v2, r_v3, r_v4;
    logic                            r_echo0;
    logic                            r_trig1, r_trig2, r_trig3, r_trig4;
    logic                            r_done1, r_done2;
    logic [ura_pkg::UNITS_W-1:0]     r_units1;
    logic [ura_pkg::LEN_W-1:0]       r_len2;
    logic                            r_val3, r_val4;
    logic [ura_pkg::SUM_W-1:0]       r_sum3;
    logic [ura_pkg::DIST_W-1:0]      r_dist4;

    // stage handshake
    logic                            rdy0, rdy1, rdy2, rdy3, rdy4;
    logic                            step1, step3;

    // control step signals
    logic                            trig_c, done_c, in_meas;
    logic [ura_pkg::TICK_W-1:0]      tick_inc;
    logic [ura_pkg::PRESC_W-1:0]     meas_presc, presc_inc;
    logic [ura_pkg::UNITS_W-1:0]     meas_units;

    // scaling, accumulation and mean
    logic [ura_pkg::DIST_PROD_W-1:0] len_prod;
    logic [ura_pkg::DIST_W-1:0]      len_sat;
    logic [ura_pkg::SUM_W-1:0]       sum_new;
    logic [IDX_W-1:0]                idx_inc;
    logic                            set_full;
    logic [MEAN_PROD_W-1:0]          mean_prod;

    assign rdy4 = !r_v4 || o_res.ready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;
    assign step1 = r_v0 && rdy1;
    assign step3 = r_v2 && rdy3;

    assign i_tick.ready         = rdy0;
    assign o_res.valid          = r_v4;
    assign o_res.trigger_level  = r_trig4;
    assign o_res.distance_valid = r_val4;
    assign o_res.distance       = r_dist4;

    // ranging control for one tick
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_presc    = r_presc;
        n_units    = r_units;
        trig_c     = 1'b0;
        done_c     = 1'b0;
        in_meas    = 1'b0;
        meas_presc = r_presc;
        meas_units = r_units;
        tick_inc   = r_tick + 1'b1;
        unique case (r_phase)
            PH_TRIGGER: begin
                trig_c = 1'b1;
                if (tick_inc >= {10'b0, r_trigger_ticks}) begin
                    n_phase = PH_WAIT;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            PH_WAIT: begin
                if (r_echo0) begin
                    // echo rise is counted as the first measuring tick
                    in_meas    = 1'b1;
                    meas_presc = '0;
                    meas_units = '0;
                    n_tick     = '0;
                end else if (tick_inc >= r_retrigger_ticks) begin
                    n_phase = PH_TRIGGER;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            PH_MEASURE: begin
                in_meas = 1'b1;
            end
            PH_GAP: begin
                if (tick_inc >= r_gap_ticks) begin
                    n_phase = PH_TRIGGER;
                    n_tick  = '0;
                end else begin
                    n_tick = tick_inc;
                end
            end
            default: begin
                n_phase = PH_TRIGGER;
            end
        endcase
        presc_inc = meas_presc + 1'b1;
        if (in_meas) begin
            if (r_echo0) begin
                n_phase = PH_MEASURE;
                if (presc_inc >= r_unit_prescale) begin
                    n_presc = '0;
                    n_units = (meas_units >= r_count_top) ? '0 : meas_units + 1'b1;
                end else begin
                    n_presc = presc_inc;
                    n_units = meas_units;
                end
            end else begin
                done_c  = 1'b1;
                n_presc = '0;
                n_units = '0;
                n_tick  = '0;
                n_phase = PH_GAP;
            end
        end
    end

    // centimetres, saturation, running sum and mean
    assign len_prod  = ura_pkg::DIST_PROD_W'(r_units1) * ura_pkg::DIST_PROD_W'(ura_pkg::DIST_MUL);
    assign len_sat   = (r_len2 > ura_pkg::LEN_W'(r_max_distance)) ? r_max_distance
                                                                  : r_len2[ura_pkg::DIST_W-1:0];
    assign sum_new   = r_sum + ura_pkg::SUM_W'(len_sat);
    assign idx_inc   = r_idx + 1'b1;
    assign set_full  = idx_inc >= IDX_W'(SAMPLES);
    assign mean_prod = MEAN_PROD_W'(r_sum3) * MEAN_PROD_W'(MEAN_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks   <= ura_pkg::RST_TRIGGER_TICKS;
            r_retrigger_ticks <= ura_pkg::RST_RETRIGGER_TICKS;
            r_unit_prescale   <= ura_pkg::RST_UNIT_PRESCALE;
            r_count_top       <= ura_pkg::RST_COUNT_TOP;
            r_max_distance    <= ura_pkg::RST_MAX_DISTANCE;
            r_gap_ticks       <= ura_pkg::RST_GAP_TICKS;
            r_phase           <= PH_TRIGGER;
            r_tick            <= '0;
            r_presc           <= '0;
            r_units           <= '0;
            r_idx             <= '0;
            r_sum             <= '0;
            r_v0              <= 1'b0;
            r_v1              <= 1'b0;
            r_v2              <= 1'b0;
            r_v3              <= 1'b0;
            r_v4              <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ura_pkg::CFG_TRIGGER_TICKS:   r_trigger_ticks   <= i_cfg_data[9:0];
                    ura_pkg::CFG_RETRIGGER_TICKS: r_retrigger_ticks <= i_cfg_data;
                    ura_pkg::CFG_UNIT_PRESCALE:   r_unit_prescale   <= i_cfg_data[15:0];
                    ura_pkg::CFG_COUNT_TOP:       r_count_top       <= i_cfg_data[15:0];
                    ura_pkg::CFG_MAX_DISTANCE:    r_max_distance    <= i_cfg_data[9:0];
                    ura_pkg::CFG_GAP_TICKS:       r_gap_ticks       <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // input register
            if (rdy0) begin
                r_v0    <= i_tick.valid;
                r_echo0 <= i_tick.echo_level;
            end

            // control step
            if (rdy1) begin
                r_v1     <= r_v0;
                r_trig1  <= trig_c;
                r_done1  <= done_c;
                r_units1 <= r_units;
            end
            if (step1) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_presc <= n_presc;
                r_units <= n_units;
            end

            // scaling multiply
            if (rdy2) begin
                r_v2    <= r_v1;
                r_trig2 <= r_trig1;
                r_done2 <= r_done1;
                r_len2  <= len_prod[ura_pkg::DIST_PROD_W-1 -: ura_pkg::LEN_W];
            end

            // saturate and accumulate
            if (rdy3) begin
                r_v3    <= r_v2;
                r_trig3 <= r_trig2;
                r_val3  <= r_done2 && set_full;
                r_sum3  <= sum_new;
            end
            if (step3 && r_done2) begin
                if (set_full) begin
                    r_idx <= '0;
                    r_sum <= '0;
                end else begin
                    r_idx <= idx_inc;
                    r_sum <= sum_new;
                end
            end

            // mean into the output register
            if (rdy4) begin
                r_v4    <= r_v3;
                r_trig4 <= r_trig3;
                r_val4  <= r_val3;
                r_dist4 <= r_val3 ? mean_prod[ura_pkg::MEAN_SHIFT +: ura_pkg::DIST_W] : '0;
            end
        end
    end

    // the reading count never reaches the set size between beats
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx < IDX_W'(SAMPLES))
        else $error("reading index out of range");

    // measuring only ever starts from waiting for the echo
    a_measure_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase == PH_MEASURE) |-> $past(r_phase == PH_WAIT))
        else $error("measure entered from wrong phase");

    // a mean is never emitted on a trigger beat
    a_trig_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> !(r_trig4 && r_val4))
        else $error("trigger and distance on the same beat");

    // distance reads zero on beats without a mean
    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r_val4) |-> (r_dist4 == '0))
        else $error("distance set without a mean");

endmodule
